// ===== rtl/dcc_packet_serializer_defines.svh =====
// ----------------------------------------------------------------------------
// DCC packet serializer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DCC_PACKET_SERIALIZER_DEFINES_SVH
`define DCC_PACKET_SERIALIZER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcc serializer: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define DCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcc serializer: next-cycle check failed");

`endif

// ===== rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// DCC packet serializer package
// Codes, constants and types shared by the serializer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcc_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_LOCO_ADDRESS    = 2'd0,
        REG_HALF_ONE_PERIOD = 2'd1,
        REG_LEAD_DELAY      = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_COMPARE = 1'b1
    } op_t;

    localparam logic [13:0] LOCO_ADDRESS_RST    = 14'd11;
    localparam logic [14:0] HALF_ONE_PERIOD_RST = 15'd225;
    localparam logic [15:0] LEAD_DELAY_RST      = 16'd16;

    localparam logic [13:0] LONG_ADDR_MIN = 14'd100;
    localparam logic [1:0]  LONG_PREFIX   = 2'b11;   // 0xC0 on the top address byte
    localparam logic [2:0]  FUNC_PREFIX   = 3'b100;  // 0x80
    localparam logic [1:0]  SPEED_PREFIX  = 2'b01;   // 0x40, bit 5 = direction

    localparam logic [15:0] PREAMBLE_WORD = 16'hAFFF;
    localparam logic [15:0] MASK_FIRST    = 16'h8000;
    localparam logic [15:0] MASK_BYTE     = 16'h0100;
    localparam logic [15:0] MASK_TAIL     = 16'h0004;
    localparam logic [15:0] TAIL_WORD     = 16'hFFFF;

    localparam logic [2:0] BYTE_LAST = 3'd4;
    localparam logic [2:0] BYTE_END  = 3'd5;

    typedef struct packed {
        logic        line_level;
        logic [15:0] half_period;
        logic        driving;
        logic        packet_done;
    } result_t;

endpackage

// ===== rtl/dcc_packet_serializer.sv =====
// ----------------------------------------------------------------------------
// DCC packet serializer
// Builds a DCC packet on a start item and steps it out half-bit by half-bit.
// ----------------------------------------------------------------------------
// One item is taken per clock unless in_stall is high; its result is
// registered into the result register, or the skid register when a stall
// holds it. An item's work is one pass of select logic on the serializer
// state; this two-entry buffer lets the next item in while a result is held.
// Configuration is through a 4-bit APB port: loco_address at 0x0,
// half_one_period at 0x4, lead_delay at 0x8.
`timescale 1ns / 1ps

module dcc_packet_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcc_pkg::PADDR_W-1:0] paddr,
    input  logic [dcc_pkg::PDATA_W-1:0] pwdata,
    output logic [dcc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [4:0]                  speed_code,
    input  logic                        forwards,
    input  logic [4:0]                  function_bits,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        line_level,
    output logic [15:0]                 half_period,
    output logic                        driving,
    output logic                        packet_done
);
    import dcc_pkg::*;

    // configuration
    logic [13:0] loco_address_reg;
    logic [14:0] half_one_period_reg;
    logic [15:0] lead_delay_reg;
    logic        cfg_write;
    reg_index_t  cfg_idx;

    // serializer state
    logic [7:0]  pkt_bytes_reg [4];
    logic [7:0]  pkt_bytes_next [4];
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [15:0] shift_word_reg, shift_word_next;
    logic [15:0] bit_mask_reg, bit_mask_next;
    logic        high_phase_reg, high_phase_next;
    logic        active_reg, active_next;
    logic [1:0]  pkt_count_reg, pkt_count_next;

    // output buffer
    result_t     main_reg, main_next;
    result_t     skid_reg, skid_next;
    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        in_accept;
    logic        out_fire;
    result_t     res;
    logic        long_addr;
    logic [7:0]  instr;
    logic [15:0] bit_len;
    logic [15:0] mask_shifted;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loco_address_reg    <= LOCO_ADDRESS_RST;
            half_one_period_reg <= HALF_ONE_PERIOD_RST;
            lead_delay_reg      <= LEAD_DELAY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_LOCO_ADDRESS:    loco_address_reg    <= pwdata[13:0];
                REG_HALF_ONE_PERIOD: half_one_period_reg <= pwdata[14:0];
                REG_LEAD_DELAY:      lead_delay_reg      <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LOCO_ADDRESS:    prdata = {18'd0, loco_address_reg};
            REG_HALF_ONE_PERIOD: prdata = {17'd0, half_one_period_reg};
            REG_LEAD_DELAY:      prdata = {16'd0, lead_delay_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_fire  = main_valid_reg && !out_stall;

    // ---------------- item processing ----------------
    assign long_addr    = (loco_address_reg >= LONG_ADDR_MIN);
    assign bit_len      = ((shift_word_reg & bit_mask_reg) == 16'd0)
                          ? {half_one_period_reg, 1'b0}
                          : {1'b0, half_one_period_reg};
    assign mask_shifted = bit_mask_reg >> 1;

    always_comb
    begin
        pkt_bytes_next  = pkt_bytes_reg;
        byte_index_next = byte_index_reg;
        shift_word_next = shift_word_reg;
        bit_mask_next   = bit_mask_reg;
        high_phase_next = high_phase_reg;
        active_next     = active_reg;
        pkt_count_next  = pkt_count_reg;
        instr           = 8'd0;
        res             = '{line_level: 1'b0, half_period: 16'd0,
                            driving: 1'b0, packet_done: 1'b0};

        case (op_t'(operation))
            OP_START:
            begin
                pkt_count_next = pkt_count_reg + 2'd1;
                if (pkt_count_next == 2'd0)
                    instr = {FUNC_PREFIX, function_bits};
                else
                    instr = {SPEED_PREFIX, forwards, speed_code};
                pkt_bytes_next[0] = long_addr ? {LONG_PREFIX, loco_address_reg[13:8]} : 8'd0;
                pkt_bytes_next[1] = loco_address_reg[7:0];
                pkt_bytes_next[2] = instr;
                pkt_bytes_next[3] = pkt_bytes_next[0] ^ pkt_bytes_next[1] ^ instr;
                byte_index_next   = long_addr ? 3'd0 : 3'd1;
                shift_word_next   = PREAMBLE_WORD;
                bit_mask_next     = MASK_FIRST;
                high_phase_next   = 1'b0;
                active_next       = 1'b1;
                res = '{line_level: 1'b1, half_period: lead_delay_reg,
                        driving: 1'b1, packet_done: 1'b0};
            end
            OP_COMPARE:
            begin
                if (active_reg)
                begin
                    if (!high_phase_reg)
                    begin
                        high_phase_next = 1'b1;
                        res = '{line_level: 1'b0, half_period: bit_len,
                                driving: 1'b1, packet_done: 1'b0};
                    end
                    else
                    begin
                        high_phase_next = 1'b0;
                        bit_mask_next   = mask_shifted;
                        res = '{line_level: 1'b1, half_period: bit_len,
                                driving: 1'b1, packet_done: 1'b0};
                        if (mask_shifted == 16'd0)
                        begin
                            // byte boundary: start bit comes from bit 8 of the mask
                            bit_mask_next = MASK_BYTE;
                            if (byte_index_reg >= BYTE_END)
                            begin
                                active_next = 1'b0;
                                res = '{line_level: 1'b0, half_period: 16'd0,
                                        driving: 1'b0, packet_done: 1'b1};
                            end
                            else if (byte_index_reg == BYTE_LAST)
                            begin
                                // trailing ones: bits 2..0, the first in the start-bit slot
                                byte_index_next = BYTE_END;
                                shift_word_next = TAIL_WORD;
                                bit_mask_next   = MASK_TAIL;
                            end
                            else
                            begin
                                shift_word_next = {8'd0, pkt_bytes_reg[byte_index_reg[1:0]]};
                                byte_index_next = byte_index_reg + 3'd1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            shift_word_reg <= '0;
            bit_mask_reg   <= '0;
            high_phase_reg <= 1'b0;
            active_reg     <= 1'b0;
            pkt_count_reg  <= '0;
        end
        else if (in_accept)
        begin
            byte_index_reg <= byte_index_next;
            shift_word_reg <= shift_word_next;
            bit_mask_reg   <= bit_mask_next;
            high_phase_reg <= high_phase_next;
            active_reg     <= active_next;
            pkt_count_reg  <= pkt_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            pkt_bytes_reg <= pkt_bytes_next;
    end

    // ---------------- output buffer ----------------
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = main_valid_reg;
    assign line_level  = main_reg.line_level;
    assign half_period = main_reg.half_period;
    assign driving     = main_reg.driving;
    assign packet_done = main_reg.packet_done;

endmodule

// ===== rtl/dcc_checker.sv =====
// ----------------------------------------------------------------------------
// DCC packet serializer port checker
// Watches result items on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dcc_packet_serializer_defines.svh"

module dcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        line_level,
    input logic [15:0] half_period,
    input logic        driving,
    input logic        packet_done
);

    // end of packet releases the line with a zero length
    `DCC_ASSERT_SAME(a_done_released, out_valid && packet_done, !driving && !line_level && half_period == 16'd0)

    // a released line never carries a level or a length
    `DCC_ASSERT_SAME(a_idle_quiet, out_valid && !driving, !line_level && half_period == 16'd0)

    // high level only while driving
    `DCC_ASSERT_SAME(a_high_driving, out_valid && line_level, driving)

    // stalled item holds
    `DCC_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(half_period) && $stable(line_level))

endmodule

bind dcc_packet_serializer dcc_checker u_dcc_checker (.*);

// ===== verif/dcc_serializer_checker.sv =====
// ----------------------------------------------------------------------------
// DCC serializer result checker
// Follows config writes and accepted items, predicts each line event of the
// serializer and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcc_serializer_checker
    import dcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                operation,
    input  logic [4:0]          speed_code,
    input  logic                forwards,
    input  logic [4:0]          function_bits,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                line_level,
    input  logic [15:0]         half_period,
    input  logic                driving,
    input  logic                packet_done,
    output int                  mismatches,
    output int                  outstanding,
    output int                  packets_finished
);

    localparam logic [2:0] TAIL_SLOT  = 3'd4;
    localparam logic [2:0] DONE_SLOT  = 3'd5;
    localparam int         MAX_REPORT = 10;

    // configuration copy
    logic [13:0] loco_cfg;
    logic [14:0] half_cfg;
    logic [15:0] lead_cfg;

    // serializer state copy
    logic [7:0]  pkt_bytes [4];
    logic [2:0]  byte_slot;
    logic [15:0] bit_word;
    logic [15:0] bit_sel;
    logic        high_next;
    logic        sending;
    logic [1:0]  pkt_count;

    result_t expected_events [$];
    int      error_total;
    int      done_total;

    function automatic result_t next_line_event(input op_t op, input logic [4:0] spd,
                                                input logic fwd, input logic [4:0] fn);
        result_t    ev;
        logic [7:0] instr;
        logic [15:0] span;
        ev = '0;
        if (op == OP_START)
        begin
            pkt_count    = pkt_count + 2'd1;
            pkt_bytes[0] = 8'h00;
            pkt_bytes[1] = loco_cfg[7:0];
            byte_slot    = 3'd1;
            if (loco_cfg >= 14'd100)
            begin
                pkt_bytes[0] = {2'b11, loco_cfg[13:8]};
                byte_slot    = 3'd0;
            end
            // every fourth packet carries function group one
            if (pkt_count == 2'd0)
                instr = {3'b100, fn};
            else
                instr = {2'b01, fwd, spd};
            pkt_bytes[2] = instr;
            pkt_bytes[3] = pkt_bytes[0] ^ pkt_bytes[1] ^ instr;
            bit_word  = 16'hAFFF;
            bit_sel   = 16'h8000;
            high_next = 1'b0;
            sending   = 1'b1;
            ev.line_level  = 1'b1;
            ev.half_period = lead_cfg;
            ev.driving     = 1'b1;
            return ev;
        end
        if (!sending)
            return ev;
        span = {1'b0, half_cfg};
        if ((bit_word & bit_sel) == 16'h0000)
            span = {half_cfg, 1'b0};
        if (!high_next)
        begin
            high_next      = 1'b1;
            ev.half_period = span;
            ev.driving     = 1'b1;
            return ev;
        end
        high_next = 1'b0;
        bit_sel   = bit_sel >> 1;
        if (bit_sel == 16'h0000)
        begin
            // byte boundary: start bit comes from bit 8 of the loaded word
            bit_sel = 16'h0100;
            if (byte_slot >= DONE_SLOT)
            begin
                sending        = 1'b0;
                ev.packet_done = 1'b1;
                return ev;
            end
            if (byte_slot == TAIL_SLOT)
            begin
                byte_slot = DONE_SLOT;
                bit_word  = 16'hFFFF;
                bit_sel   = 16'h0004;
            end
            else
            begin
                bit_word  = {8'h00, pkt_bytes[byte_slot[1:0]]};
                byte_slot = byte_slot + 3'd1;
            end
        end
        ev.line_level  = 1'b1;
        ev.half_period = span;
        ev.driving     = 1'b1;
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            loco_cfg  = 14'd11;
            half_cfg  = 15'd225;
            lead_cfg  = 16'd16;
            for (int i = 0; i < 4; i++)
                pkt_bytes[i] = 8'h00;
            byte_slot = 3'd0;
            bit_word  = 16'h0000;
            bit_sel   = 16'h0000;
            high_next = 1'b0;
            sending   = 1'b0;
            pkt_count = 2'd0;
            expected_events.delete();
            error_total = 0;
            done_total  = 0;
            mismatches       <= 0;
            outstanding      <= 0;
            packets_finished <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {line_level, half_period, driving, packet_done};
                if (seen.packet_done)
                    done_total++;
                if (expected_events.size() == 0)
                begin
                    error_total++;
                    if (error_total <= MAX_REPORT)
                        $display("%0t: result with nothing expected: lvl=%0d hp=%0d drv=%0d done=%0d",
                                 $realtime, seen.line_level, seen.half_period, seen.driving,
                                 seen.packet_done);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (seen.line_level !== want.line_level ||
                        seen.half_period !== want.half_period ||
                        seen.driving !== want.driving ||
                        seen.packet_done !== want.packet_done)
                    begin
                        error_total++;
                        if (error_total <= MAX_REPORT)
                            $display("%0t: mismatch: expected lvl=%0d hp=%0d drv=%0d done=%0d, got lvl=%0d hp=%0d drv=%0d done=%0d",
                                     $realtime, want.line_level, want.half_period, want.driving,
                                     want.packet_done, seen.line_level, seen.half_period,
                                     seen.driving, seen.packet_done);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_LOCO_ADDRESS:    loco_cfg = pwdata[13:0];
                    REG_HALF_ONE_PERIOD: half_cfg = pwdata[14:0];
                    REG_LEAD_DELAY:      lead_cfg = pwdata[15:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_events.push_back(next_line_event(op_t'(operation), speed_code,
                                                          forwards, function_bits));

            mismatches       <= error_total;
            outstanding      <= expected_events.size();
            packets_finished <= done_total;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// DCC packet serializer testbench
// Drives start and compare items in bursts against a stalling receiver, over
// a series of address, bit-timing and lead-delay settings; a checker beside
// the block predicts every line event and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dcc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 140;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int SHORT_EVENTS = 92;   // compares in a packet with a one-byte address
    localparam int LONG_EVENTS  = 110;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [4:0]          speed_code;
    logic                forwards;
    logic [4:0]          function_bits;
    logic                out_valid;
    logic                out_stall;
    logic                line_level;
    logic [15:0]         half_period;
    logic                driving;
    logic                packet_done;

    int mismatches;
    int outstanding;
    int packets_finished;

    int items_sent;
    int starts_sent;
    int burst_left;
    bit offering;
    int cur_loco;
    int hold_kicks;
    int cycle_count;

    // receiver stall state
    int stall_mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    int pattern_count;
    bit stall_now;

    always #5 clk = ~clk;

    dcc_packet_serializer dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .speed_code(speed_code), .forwards(forwards), .function_bits(function_bits),
        .out_valid(out_valid), .out_stall(out_stall), .line_level(line_level),
        .half_period(half_period), .driving(driving), .packet_done(packet_done)
    );

    dcc_serializer_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .speed_code(speed_code), .forwards(forwards), .function_bits(function_bits),
        .out_valid(out_valid), .out_stall(out_stall), .line_level(line_level),
        .half_period(half_period), .driving(driving), .packet_done(packet_done),
        .mismatches(mismatches), .outstanding(outstanding),
        .packets_finished(packets_finished)
    );

    // receiver: random stall modes, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_kicks)
        begin
            hold_seen = hold_kicks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            stall_now = 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            pattern_count++;
            case (stall_mode)
                0: stall_now = 1'b0;
                1: stall_now = 1'($urandom_range(0, 1));
                2: stall_now = ($urandom_range(0, 9) < 8);
                default: stall_now = (pattern_count % 4) != 0;
            endcase
        end
        out_stall <= stall_now;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycle_count,
                 outstanding);
        $display("TB_ERROR");
        $finish;
    end

    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // burst and gap pacing of the sender
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic offer(input op_t op, input logic [4:0] spd, input logic fwd,
                         input logic [4:0] fn);
        in_valid      <= 1'b1;
        offering      = 1'b1;
        operation     <= op;
        speed_code    <= spd;
        forwards      <= fwd;
        function_bits <= fn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op == OP_START)
            starts_sent++;
        pace();
    endtask

    task automatic offer_random(input op_t op);
        offer(op, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
              5'($urandom_range(0, 31)));
    endtask

    task automatic send_packet(input int compares);
        offer_random(OP_START);
        repeat (compares) offer_random(OP_COMPARE);
    endtask

    // sender pauses until every expected result is back
    task automatic settle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase_start;
        int full;
        int kind;
        logic [13:0] loco_val;
        logic [14:0] half_val;
        logic [15:0] lead_val;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        operation     = OP_START;
        speed_code    = 5'd0;
        forwards      = 1'b0;
        function_bits = 5'd0;
        items_sent    = 0;
        starts_sent   = 0;
        burst_left    = 8;
        offering      = 1'b0;
        cur_loco      = 11;
        hold_kicks    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: idle compares, field extremes, restarts, a function packet
        offer(OP_COMPARE, 5'd31, 1'b1, 5'd31);
        offer(OP_COMPARE, 5'd0, 1'b0, 5'd0);
        offer(OP_START, 5'd0, 1'b0, 5'd0);
        repeat (4) offer_random(OP_COMPARE);
        offer(OP_START, 5'd31, 1'b1, 5'd0);
        repeat (3) offer_random(OP_COMPARE);
        offer(OP_START, 5'd21, 1'b0, 5'd10);
        offer(OP_START, 5'd10, 1'b1, 5'd31);
        offer(OP_START, 5'd0, 1'b1, 5'd0);
        repeat (5) offer_random(OP_COMPARE);
        offer(OP_START, 5'd31, 1'b0, 5'd21);
        offer_random(OP_COMPARE);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: begin loco_val = 14'd0;     half_val = 15'd1;     lead_val = 16'd1;     end
                1: begin loco_val = 14'd99;    half_val = 15'd32767; lead_val = 16'd65535; end
                2: begin loco_val = 14'd100;   half_val = 15'd0;     lead_val = 16'd16;    end
                3:
                begin
                    loco_val = 14'd16383;
                    half_val = 15'd225;
                    lead_val = 16'($urandom_range(1, 65535));
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        loco_val = 14'($urandom_range(0, 99));
                    else
                        loco_val = 14'($urandom_range(100, 16383));
                    half_val = 15'($urandom_range(1, 32767));
                    lead_val = 16'($urandom_range(1, 65535));
                end
            endcase
            apb_write(REG_LOCO_ADDRESS, {18'd0, loco_val});
            apb_write(REG_HALF_ONE_PERIOD, {17'd0, half_val});
            apb_write(REG_LEAD_DELAY, {16'd0, lead_val});
            cur_loco = int'(loco_val);
            if (phase == 2 || phase == 5)
                hold_kicks <= hold_kicks + 1;

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                full = (cur_loco >= 100) ? LONG_EVENTS : SHORT_EVENTS;
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    repeat ($urandom_range(1, 4)) offer_random(OP_COMPARE);
                else if (kind < 3)
                    send_packet($urandom_range(0, full - 1));
                else
                    send_packet(full + $urandom_range(0, 2));
            end
        end

        settle();

        $display("sent %0d items (%0d packet starts) over %0d register settings",
                 items_sent, starts_sent, PHASES + 1);
        $display("%0d packets ran to their final edge; %0d mismatches, %0d results missing",
                 packets_finished, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
